// ===== rtl/variable_delay_interpolator_defines.svh =====
// ----------------------------------------------------------------------------
// Variable delay interpolator assertion macros
// Assertion helpers shared by the interpolator RTL; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef VARIABLE_DELAY_INTERPOLATOR_DEFINES_SVH
`define VARIABLE_DELAY_INTERPOLATOR_DEFINES_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define VDI_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define VDI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define VDI_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define VDI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/vdi_pkg.sv =====
// ----------------------------------------------------------------------------
// Variable delay interpolator package
// Sizes, register indexes, controller command and status types, helpers.
// ----------------------------------------------------------------------------
package vdi_pkg;

  localparam int DEPTH   = 1024;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int DATA_W  = 32;
  localparam int MD_W    = 20;
  localparam int TGT_W   = DATA_W + 1;
  localparam int NUM_W   = DATA_W + 1;
  localparam int DV_W    = DATA_W;
  localparam int PROD_W  = NUM_W + DV_W;
  localparam int DCNT_W  = $clog2(PROD_W);
  localparam int QCAP_W  = 41;
  localparam int RES_W   = QCAP_W + 2;
  localparam int LAD_W   = MD_W + $clog2(DEPTH + 1) + 1;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_VALUE = 1'd1;
  localparam logic [MD_W-1:0]      MD_RESET       = 20'd1024;

  typedef struct packed {
    logic init;
    logic clear;
    logic accept;
    logic rd_old;
    logic rd_new;
    logic store;
    logic srch_rd;
    logic srch_cmp;
    logic rd_a;
    logic rd_b;
    logic prep;
    logic mul;
    logic div;
    logic fin;
  } vdi_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic srch_done;
    logic den_zero;
    logic mul_done;
    logic div_done;
    logic out_busy;
  } vdi_stat_t;

  // Position off entries above the oldest entry, wrapped round the ring.
  function automatic logic [ADDR_W-1:0] ring_idx(input logic [ADDR_W-1:0] off,
                                                 input logic [ADDR_W-1:0] base);
    logic [ADDR_W:0] s;
    s = {1'b0, off} + {1'b0, base};
    if (s >= (ADDR_W+1)'(DEPTH)) s = s - (ADDR_W+1)'(DEPTH);
    return s[ADDR_W-1:0];
  endfunction

  // Saturates a ladder time to the signed 32-bit range.
  function automatic logic [DATA_W-1:0] sat_lad(input logic signed [LAD_W-1:0] v);
    if (v < -(LAD_W'(64'sd2147483648))) return {1'b1, {(DATA_W-1){1'b0}}};
    if (v > LAD_W'(64'sd2147483647)) return {1'b0, {(DATA_W-1){1'b1}}};
    return v[DATA_W-1:0];
  endfunction

endpackage

// ===== rtl/vdi_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module vdi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/vdi_datapath.sv =====
// ----------------------------------------------------------------------------
// Variable delay interpolator datapath
// Registers, ring memories, search bounds, shift-add multiplier and divider.
// ----------------------------------------------------------------------------
`include "variable_delay_interpolator_defines.svh"

module vdi_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  vdi_pkg::vdi_cmd_t                   cmd,
  output vdi_pkg::vdi_stat_t                  stat,
  input  logic                                cfg_we,
  input  logic [vdi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [vdi_pkg::DATA_W-1:0]          cfg_wdata,
  input  logic signed [vdi_pkg::DATA_W-1:0]   in_sample_time,
  input  logic signed [vdi_pkg::DATA_W-1:0]   in_delay_request,
  input  logic signed [vdi_pkg::DATA_W-1:0]   in_sample_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [vdi_pkg::DATA_W-1:0]   out_delayed_value,
  output logic                                out_underrun
);

  localparam int AW = vdi_pkg::ADDR_W;
  localparam int DW = vdi_pkg::DATA_W;
  localparam int PW = vdi_pkg::PROD_W;
  localparam int QW = vdi_pkg::QCAP_W;
  localparam int RW = vdi_pkg::RES_W;

  logic [vdi_pkg::MD_W-1:0]    md_r;
  logic [DW-1:0]               iv_r;
  logic [DW-1:0]               t_r, v_r;
  logic [vdi_pkg::TGT_W-1:0]   tgt_r, tgt_nxt;
  logic                        under_r;
  logic [AW-1:0]               wi_r, wi_nxt, newest;
  logic [AW-1:0]               cnt_r;
  logic signed [vdi_pkg::LAD_W-1:0] acc_r;
  logic [AW-1:0]               lo_r, hi_r, lo_nxt, hi_nxt, mid;
  logic [AW:0]                 mid_sum;
  logic [DW-1:0]               ti_r, va_r;
  logic [DW-1:0]               den_mag_r, rem_r;
  logic                        neg_r, zero_r;
  logic [PW-1:0]               prod_r, mcand_r;
  logic [vdi_pkg::NUM_W-1:0]   mlr_r;
  logic [vdi_pkg::DCNT_W-1:0]  dcnt_r;
  logic [DW-1:0]               out_val_r;
  logic                        out_under_r, out_valid_r;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [DW-1:0]   ram_wt, ram_wv, rd_t, rd_v;

  localparam int MD_W_CL = vdi_pkg::MD_W;
  logic [MD_W_CL-1:0] dcl;
  logic            newer, tgt_lt, tgt_gt;
  logic [DW+1:0]   num1;
  logic [DW:0]     den, dv, num1_abs_lo, dv_abs, den_abs;
  logic [DW+1:0]   num1_abs;
  logic [DW:0]     rem_sh;
  logic            q_over;
  logic [QW-1:0]   qc;
  logic [RW-1:0]   sq, res_sum;
  logic [DW-1:0]   res_sat;

  // Requested delay clamped to 0..max_delay, target formed one bit wider.
  always_comb begin
    if (in_delay_request[DW-1]) dcl = '0;
    else if (in_delay_request[DW-2:0] > (DW-1)'(md_r)) dcl = md_r;
    else dcl = in_delay_request[vdi_pkg::MD_W-1:0];
    tgt_nxt = {in_sample_time[DW-1], in_sample_time} - vdi_pkg::TGT_W'(dcl);
  end

  assign newest  = (wi_r == '0) ? AW'(vdi_pkg::DEPTH - 1) : wi_r - 1'b1;
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[AW:1];
  assign newer   = $signed(t_r) > $signed(rd_t);
  assign tgt_lt  = $signed(tgt_r) < $signed({rd_t[DW-1], rd_t});
  assign tgt_gt  = $signed(tgt_r) > $signed({rd_t[DW-1], rd_t});

  // Ring memory port selection.
  always_comb begin
    ram_we    = cmd.clear || cmd.store;
    ram_waddr = cnt_r;
    ram_wt    = vdi_pkg::sat_lad(acc_r);
    ram_wv    = iv_r;
    if (cmd.store) begin
      ram_waddr = newer ? wi_r : newest;
      ram_wt    = t_r;
      ram_wv    = v_r;
    end
    ram_raddr = wi_r;
    if (cmd.rd_old) ram_raddr = wi_r;
    else if (cmd.rd_new) ram_raddr = newest;
    else if (cmd.srch_rd) ram_raddr = vdi_pkg::ring_idx(mid, wi_r);
    else if (cmd.rd_a) ram_raddr = vdi_pkg::ring_idx(lo_r, wi_r);
    else if (cmd.rd_b) ram_raddr = vdi_pkg::ring_idx(hi_r, wi_r);
  end

  vdi_ram #(.WIDTH(DW), .DEPTH(vdi_pkg::DEPTH)) u_time_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wt),
    .raddr(ram_raddr), .rdata(rd_t)
  );

  vdi_ram #(.WIDTH(DW), .DEPTH(vdi_pkg::DEPTH)) u_value_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wv),
    .raddr(ram_raddr), .rdata(rd_v)
  );

  // Search bounds.
  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    wi_nxt = wi_r;
    if (cmd.store) begin
      lo_nxt = '0;
      hi_nxt = AW'(vdi_pkg::DEPTH - 1);
      if (newer) wi_nxt = vdi_pkg::ring_idx(AW'(1), wi_r);
    end else if (cmd.srch_cmp) begin
      if (tgt_lt) hi_nxt = mid;
      else if (tgt_gt) lo_nxt = mid;
      else begin
        lo_nxt = mid;
        hi_nxt = mid;
      end
    end
  end

  // Differences for the interpolation.
  always_comb begin
    num1 = {tgt_r[vdi_pkg::TGT_W-1], tgt_r} - {{2{ti_r[DW-1]}}, ti_r};
    den  = {rd_t[DW-1], rd_t} - {ti_r[DW-1], ti_r};
    dv   = {rd_v[DW-1], rd_v} - {va_r[DW-1], va_r};
    num1_abs    = num1[DW+1] ? -num1 : num1;
    num1_abs_lo = num1_abs[DW:0];
    dv_abs      = dv[DW] ? -dv : dv;
    den_abs     = den[DW] ? -den : den;
    rem_sh      = {rem_r, prod_r[PW-1]};
  end

  // Quotient capping, sign, offset and saturation.
  always_comb begin
    q_over = (|prod_r[PW-1:QW]) || (prod_r[QW-1] && (|prod_r[QW-2:0]));
    qc     = q_over ? {1'b1, {(QW-1){1'b0}}} : prod_r[QW-1:0];
    sq     = {2'b00, qc};
    if (neg_r) sq = -sq - RW'(rem_r != '0);
    res_sum = {{(RW-DW){va_r[DW-1]}}, va_r} + sq;
    if (res_sum[RW-1] && !(&res_sum[RW-2:DW-1])) res_sat = {1'b1, {(DW-1){1'b0}}};
    else if (!res_sum[RW-1] && (|res_sum[RW-2:DW-1])) res_sat = {1'b0, {(DW-1){1'b1}}};
    else res_sat = res_sum[DW-1:0];
    if (zero_r) res_sat = va_r;
  end

  // Configuration registers and control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      md_r        <= vdi_pkg::MD_RESET;
      iv_r        <= '0;
      wi_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          vdi_pkg::CFG_MAX_DELAY:  md_r <= cfg_wdata[vdi_pkg::MD_W-1:0];
          vdi_pkg::CFG_INIT_VALUE: iv_r <= cfg_wdata;
        endcase
      end
      if (cmd.init) wi_r <= '0;
      else wi_r <= wi_nxt;
      if (cmd.fin) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      cnt_r <= '0;
      acc_r <= -$signed(vdi_pkg::LAD_W'(md_r) * vdi_pkg::LAD_W'(vdi_pkg::DEPTH));
    end
    if (cmd.clear) begin
      cnt_r <= cnt_r + 1'b1;
      acc_r <= acc_r + $signed(vdi_pkg::LAD_W'(md_r));
    end
    if (cmd.accept) begin
      t_r   <= in_sample_time;
      v_r   <= in_sample_value;
      tgt_r <= tgt_nxt;
    end
    if (cmd.rd_new) under_r <= tgt_lt;
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    if (cmd.rd_b) begin
      ti_r <= rd_t;
      va_r <= rd_v;
    end
    if (cmd.prep) begin
      zero_r    <= (den == '0);
      neg_r     <= num1[DW+1] ^ dv[DW] ^ den[DW];
      den_mag_r <= den_abs[DW-1:0];
      mlr_r     <= num1_abs_lo;
      mcand_r   <= PW'(dv_abs[DW-1:0]);
      prod_r    <= '0;
      rem_r     <= '0;
      dcnt_r    <= '0;
    end
    if (cmd.mul && (mlr_r != '0)) begin
      if (mlr_r[0]) prod_r <= prod_r + mcand_r;
      mcand_r <= {mcand_r[PW-2:0], 1'b0};
      mlr_r   <= {1'b0, mlr_r[vdi_pkg::NUM_W-1:1]};
    end
    if (cmd.div) begin
      if (rem_sh >= {1'b0, den_mag_r}) begin
        rem_r  <= rem_sh[DW-1:0] - den_mag_r;
        prod_r <= {prod_r[PW-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh[DW-1:0];
        prod_r <= {prod_r[PW-2:0], 1'b0};
      end
      dcnt_r <= dcnt_r + 1'b1;
    end
    if (cmd.fin) begin
      out_val_r   <= res_sat;
      out_under_r <= under_r;
    end
  end

  always_comb begin
    stat.sweep_last = (cnt_r == AW'(vdi_pkg::DEPTH - 1));
    stat.srch_done  = ((hi_nxt - lo_nxt) <= AW'(1));
    stat.den_zero   = (den == '0);
    stat.mul_done   = (mlr_r == '0);
    stat.div_done   = (dcnt_r == vdi_pkg::DCNT_W'(PW - 1));
    stat.out_busy   = out_valid_r && !out_ready;
  end

  assign out_valid         = out_valid_r;
  assign out_delayed_value = out_val_r;
  assign out_underrun      = out_under_r;

  `VDI_ASSERT_NEXT(a_div_rem_below_den, clk, rst_n, cmd.div, rem_r < den_mag_r, "remainder not below divisor")
  `VDI_ASSERT_NEXT(a_fin_loads_output, clk, rst_n, cmd.fin, out_valid_r, "result not presented after finish")
  `VDI_ASSERT_SAME(a_bounds_ordered, clk, rst_n, cmd.srch_rd || cmd.srch_cmp || cmd.rd_a, lo_r <= hi_r, "search bounds crossed")

endmodule

// ===== rtl/vdi_ctrl.sv =====
// ----------------------------------------------------------------------------
// Variable delay interpolator controller
// Sequences ring clearing, store, search, multiply, divide and result hand-off.
// ----------------------------------------------------------------------------
`include "variable_delay_interpolator_defines.svh"

module vdi_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               cfg_we,
  input  vdi_pkg::vdi_stat_t stat,
  output vdi_pkg::vdi_cmd_t  cmd
);

  typedef enum logic [13:0] {
    ST_INIT     = 14'b00000000000001,
    ST_CLEAR    = 14'b00000000000010,
    ST_IDLE     = 14'b00000000000100,
    ST_RD_OLD   = 14'b00000000001000,
    ST_RD_NEW   = 14'b00000000010000,
    ST_STORE    = 14'b00000000100000,
    ST_SRCH_RD  = 14'b00000001000000,
    ST_SRCH_CMP = 14'b00000010000000,
    ST_RD_A     = 14'b00000100000000,
    ST_RD_B     = 14'b00001000000000,
    ST_PREP     = 14'b00010000000000,
    ST_MUL      = 14'b00100000000000,
    ST_DIV      = 14'b01000000000000,
    ST_FIN      = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT:     state_nxt = ST_CLEAR;
      ST_CLEAR:    if (stat.sweep_last) state_nxt = ST_IDLE;
      ST_IDLE:     if (in_valid) state_nxt = ST_RD_OLD;
      ST_RD_OLD:   state_nxt = ST_RD_NEW;
      ST_RD_NEW:   state_nxt = ST_STORE;
      ST_STORE:    state_nxt = stat.srch_done ? ST_RD_A : ST_SRCH_RD;
      ST_SRCH_RD:  state_nxt = ST_SRCH_CMP;
      ST_SRCH_CMP: state_nxt = stat.srch_done ? ST_RD_A : ST_SRCH_RD;
      ST_RD_A:     state_nxt = ST_RD_B;
      ST_RD_B:     state_nxt = ST_PREP;
      ST_PREP:     state_nxt = stat.den_zero ? ST_FIN : ST_MUL;
      ST_MUL:      if (stat.mul_done) state_nxt = ST_DIV;
      ST_DIV:      if (stat.div_done) state_nxt = ST_FIN;
      ST_FIN:      if (!stat.out_busy) state_nxt = ST_IDLE;
      default:     state_nxt = ST_INIT;
    endcase
    if (cfg_we) state_nxt = ST_INIT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd.init     = (state_r == ST_INIT);
    cmd.clear    = (state_r == ST_CLEAR);
    cmd.accept   = in_ready && in_valid;
    cmd.rd_old   = (state_r == ST_RD_OLD);
    cmd.rd_new   = (state_r == ST_RD_NEW);
    cmd.store    = (state_r == ST_STORE);
    cmd.srch_rd  = (state_r == ST_SRCH_RD);
    cmd.srch_cmp = (state_r == ST_SRCH_CMP);
    cmd.rd_a     = (state_r == ST_RD_A);
    cmd.rd_b     = (state_r == ST_RD_B);
    cmd.prep     = (state_r == ST_PREP);
    cmd.mul      = (state_r == ST_MUL);
    cmd.div      = (state_r == ST_DIV);
    cmd.fin      = (state_r == ST_FIN) && !stat.out_busy;
  end

  `VDI_ASSERT_NEXT(a_accept_starts_item, clk, rst_n, cmd.accept && !cfg_we, state_r == ST_RD_OLD, "accepted word did not start processing")
  `VDI_ASSERT_NEXT(a_cfg_restarts_clear, clk, rst_n, cfg_we, state_r == ST_INIT, "configuration write did not rebuild the ring")

endmodule

// ===== rtl/variable_delay_interpolator.sv =====
// ----------------------------------------------------------------------------
// Variable delay interpolator
// Variable transport delay with linear interpolation over a ring of
// (time, value) pairs.
// ----------------------------------------------------------------------------
//
//   Channel | Ports                                   | Direction
//   --------+-----------------------------------------+----------
//   in      | in_valid/in_ready, sample fields        | to block
//   out     | out_valid/out_ready, result fields      | from block
//   cfg     | cfg_we, cfg_index, cfg_wdata            | to block
//
// A word passes through the accepting cycle, four memory reads and the store,
// a read and a compare for each binary search step over the 1024 entries,
// the shift-add multiply and the restoring divide. When the two bracketing
// times are equal the multiply and divide are skipped.
// After reset and after every configuration write the ring is rebuilt by a
// clearing pass, during which no word is accepted.
// A finished result waits in the output register; the controller stalls in
// its final state only if a second result arrives before the first is taken.
// ----------------------------------------------------------------------------

module variable_delay_interpolator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [vdi_pkg::DATA_W-1:0]   in_sample_time,
  input  logic signed [vdi_pkg::DATA_W-1:0]   in_delay_request,
  input  logic signed [vdi_pkg::DATA_W-1:0]   in_sample_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [vdi_pkg::DATA_W-1:0]   out_delayed_value,
  output logic                                out_underrun,
  input  logic                                cfg_we,
  input  logic [vdi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [vdi_pkg::DATA_W-1:0]          cfg_wdata
);

  // The controller steps through each word; the datapath owns all storage
  // and arithmetic and reports back the few conditions that steer the flow.
  vdi_pkg::vdi_cmd_t  cmd;
  vdi_pkg::vdi_stat_t stat;

  vdi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cfg_we   (cfg_we),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the time and value rings, the search bounds and the
  // sequential multiplier and divider used for the interpolation.
  vdi_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_sample_time    (in_sample_time),
    .in_delay_request  (in_delay_request),
    .in_sample_value   (in_sample_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_delayed_value (out_delayed_value),
    .out_underrun      (out_underrun)
  );

endmodule
